// ===== rtl/ddm_pkg.sv =====
// ----------------------------------------------------------------------------
// ddm_pkg: shared types and constants of the drive mixer
// Command, result and control types used by the front, the back and the top.
// ----------------------------------------------------------------------------
package ddm_pkg;

    localparam int PWM_BITS_DEFAULT = 8;
    localparam int CMD_DEPTH        = 4;
    localparam int RES_DEPTH        = 2;
    localparam int STICK_W          = 16;
    localparam int SPEED_W          = 8;
    // Quotient bits kept by the divider; anything larger saturates anyway.
    localparam int QUOT_W           = 17;

    localparam logic signed [STICK_W-1:0] LATERAL_MIN_RESET = -16'sd512;
    localparam logic signed [STICK_W-1:0] LATERAL_MAX_RESET = 16'sd511;
    localparam logic signed [STICK_W-1:0] FORWARD_MIN_RESET = -16'sd512;
    localparam logic signed [STICK_W-1:0] FORWARD_MAX_RESET = 16'sd511;

    typedef enum logic [1:0] {
        MODE_ARCADE = 2'd0,
        MODE_TANK   = 2'd1,
        MODE_SINGLE = 2'd2
    } mode_t;

    typedef enum logic [1:0] {
        DIR_STOP    = 2'd0,
        DIR_FORWARD = 2'd1,
        DIR_REVERSE = 2'd2
    } dir_t;

    typedef enum logic [1:0] {
        REG_LATERAL_MIN = 2'd0,
        REG_LATERAL_MAX = 2'd1,
        REG_FORWARD_MIN = 2'd2,
        REG_FORWARD_MAX = 2'd3
    } reg_index_t;

    typedef struct packed {
        mode_t mode;
        logic  flip;
        logic  left_en;
        logic  right_en;
        logic  pick_left;
    } ctrl_t;

    // One stick prepared for the divider: magnitudes plus quotient sign.
    typedef struct packed {
        logic [STICK_W-1:0] diff_mag;
        logic [STICK_W-1:0] span_mag;
        logic               neg;
        logic               zero;
    } lane_t;

    typedef struct packed {
        ctrl_t ctrl;
        lane_t a;
        lane_t b;
    } cmd_t;

    typedef struct packed {
        logic neg;
        logic zero;
    } lane_tag_t;

    typedef struct packed {
        ctrl_t     ctrl;
        lane_tag_t lane;
    } head_tag_t;

    typedef struct packed {
        logic [SPEED_W-1:0] speed;
        dir_t               direction;
        logic               flipped;
        logic               written;
    } side_t;

    typedef struct packed {
        side_t left;
        side_t right;
    } result_t;

endpackage

// ===== rtl/ddm_fifo.sv =====
// ----------------------------------------------------------------------------
// ddm_fifo: small register queue
// Holds up to DEPTH beats; a push while full and a pop while empty are ignored.
// ----------------------------------------------------------------------------
module ddm_fifo #(
    parameter int W     = $bits(ddm_pkg::cmd_t),
    parameter int DEPTH = ddm_pkg::CMD_DEPTH
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    input  logic [W-1:0] wr_data,
    output logic         full,
    input  logic         pop,
    output logic [W-1:0] rd_data,
    output logic         empty
);
    import ddm_pkg::*;

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic [W-1:0]  mem [0:DEPTH-1];
    logic [PW-1:0] wr_ptr_reg;
    logic [PW-1:0] wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg;
    logic [PW-1:0] rd_ptr_next;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;
    logic          do_push;
    logic          do_pop;

    assign full    = (count_reg == CW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rd_data = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= wr_data;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("queue count beyond depth");

    a_count_steady: assert property (@(posedge clk) disable iff (!rst_n)
        (push && pop && !full && !empty) |=> $stable(count_reg))
        else $error("queue count moved on a simultaneous push and pop");

endmodule

// ===== rtl/ddm_front.sv =====
// ----------------------------------------------------------------------------
// ddm_front: configuration registers and command classification
// Selects the input range of each stick and reduces it to magnitudes and a
// quotient sign, so the back end only multiplies and divides.
// ----------------------------------------------------------------------------
module ddm_front (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [1:0]                         cfg_index,
    input  logic signed [ddm_pkg::STICK_W-1:0] cfg_data,
    input  logic                               push,
    output logic                               full,
    input  logic [1:0]                         mode,
    input  logic signed [ddm_pkg::STICK_W-1:0] stick_a,
    input  logic signed [ddm_pkg::STICK_W-1:0] stick_b,
    input  logic                               inverted,
    input  logic                               left_enable,
    input  logic                               right_enable,
    input  logic                               pick_left,
    input  logic                               queue_full,
    output logic                               cmd_push,
    output ddm_pkg::cmd_t                      cmd
);
    import ddm_pkg::*;

    logic signed [STICK_W-1:0] lateral_min_reg;
    logic signed [STICK_W-1:0] lateral_max_reg;
    logic signed [STICK_W-1:0] forward_min_reg;
    logic signed [STICK_W-1:0] forward_max_reg;
    logic signed [STICK_W-1:0] a_lo;
    logic signed [STICK_W-1:0] a_hi;

    function automatic lane_t make_lane(input logic signed [STICK_W-1:0] v,
                                        input logic signed [STICK_W-1:0] lo,
                                        input logic signed [STICK_W-1:0] hi);
        logic signed [STICK_W:0] diff;
        logic signed [STICK_W:0] span;
        logic signed [STICK_W:0] diff_abs;
        logic signed [STICK_W:0] span_abs;
        lane_t                   l;
        diff       = $signed({v[STICK_W-1], v}) - $signed({lo[STICK_W-1], lo});
        span       = $signed({hi[STICK_W-1], hi}) - $signed({lo[STICK_W-1], lo});
        diff_abs   = diff[STICK_W] ? -diff : diff;
        span_abs   = span[STICK_W] ? -span : span;
        l.diff_mag = diff_abs[STICK_W-1:0];
        l.span_mag = span_abs[STICK_W-1:0];
        l.neg      = diff[STICK_W] ^ span[STICK_W];
        l.zero     = (span == '0);
        return l;
    endfunction

    assign cfg_ready = 1'b1;
    assign full      = queue_full;
    assign cmd_push  = push && !queue_full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lateral_min_reg <= LATERAL_MIN_RESET;
            lateral_max_reg <= LATERAL_MAX_RESET;
            forward_min_reg <= FORWARD_MIN_RESET;
            forward_max_reg <= FORWARD_MAX_RESET;
        end
        else if (cfg_valid)
        begin
            unique case (reg_index_t'(cfg_index))
                REG_LATERAL_MIN: lateral_min_reg <= cfg_data;
                REG_LATERAL_MAX: lateral_max_reg <= cfg_data;
                REG_FORWARD_MIN: forward_min_reg <= cfg_data;
                REG_FORWARD_MAX: forward_max_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Only the arcade lateral axis uses the lateral range.
    assign a_lo = (mode == MODE_ARCADE) ? lateral_min_reg : forward_min_reg;
    assign a_hi = (mode == MODE_ARCADE) ? lateral_max_reg : forward_max_reg;

    always_comb
    begin
        cmd.ctrl.mode      = mode_t'(mode);
        cmd.ctrl.flip      = inverted;
        cmd.ctrl.left_en   = left_enable;
        cmd.ctrl.right_en  = right_enable;
        cmd.ctrl.pick_left = pick_left;
        cmd.a              = make_lane(stick_a, a_lo, a_hi);
        cmd.b              = make_lane(stick_b, forward_min_reg, forward_max_reg);
    end

endmodule

// ===== rtl/ddm_divider.sv =====
// ----------------------------------------------------------------------------
// ddm_divider: pipelined restoring divider
// Unsigned division, one quotient bit per stage, with a leading stage that
// flags quotients too large for QUOT_W bits. A tag rides along with each beat.
// ----------------------------------------------------------------------------
module ddm_divider #(
    parameter int NUM_W  = 25,
    parameter int QUOT_W = ddm_pkg::QUOT_W,
    parameter int TAG_W  = 2
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        en,
    input  logic                        in_valid,
    input  logic [NUM_W-1:0]            num,
    input  logic [ddm_pkg::STICK_W-1:0] den,
    input  logic [TAG_W-1:0]            tag_in,
    output logic                        out_valid,
    output logic [QUOT_W-1:0]           quot,
    output logic                        ovf,
    output logic [TAG_W-1:0]            tag_out
);
    import ddm_pkg::*;

    localparam int DEN_TOP_W = STICK_W + QUOT_W;
    localparam int RW        = ((NUM_W > DEN_TOP_W) ? NUM_W : DEN_TOP_W) + 1;

    logic                valid_reg [0:QUOT_W];
    logic [RW-1:0]       rem_reg   [0:QUOT_W];
    logic [QUOT_W-1:0]   quot_reg  [0:QUOT_W];
    logic [STICK_W-1:0]  den_reg   [0:QUOT_W];
    logic                ovf_reg   [0:QUOT_W];
    logic [TAG_W-1:0]    tag_reg   [0:QUOT_W];
    logic [RW:0]         trial     [0:QUOT_W-1];
    logic                ovf_next;

    assign ovf_next = RW'(num) >= (RW'(den) << QUOT_W);

    // Stage k tries the divisor shifted to quotient bit QUOT_W-1-k.
    always_comb
    begin
        for (int k = 0; k < QUOT_W; k++)
        begin
            trial[k] = {1'b0, rem_reg[k]} - ((RW + 1)'(den_reg[k]) << (QUOT_W - 1 - k));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k <= QUOT_W; k++)
            begin
                valid_reg[k] <= 1'b0;
            end
        end
        else if (en)
        begin
            valid_reg[0] <= in_valid;
            for (int k = 0; k < QUOT_W; k++)
            begin
                valid_reg[k+1] <= valid_reg[k];
            end
        end
    end

    // A borrow out of the trial subtraction means this quotient bit is zero.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0]  <= RW'(num);
            quot_reg[0] <= '0;
            den_reg[0]  <= den;
            ovf_reg[0]  <= ovf_next;
            tag_reg[0]  <= tag_in;
            for (int k = 0; k < QUOT_W; k++)
            begin
                rem_reg[k+1]  <= trial[k][RW] ? rem_reg[k] : trial[k][RW-1:0];
                quot_reg[k+1] <= trial[k][RW] ? quot_reg[k]
                                              : (quot_reg[k] | (QUOT_W'(1) << (QUOT_W - 1 - k)));
                den_reg[k+1]  <= den_reg[k];
                ovf_reg[k+1]  <= ovf_reg[k];
                tag_reg[k+1]  <= tag_reg[k];
            end
        end
    end

    assign out_valid = valid_reg[QUOT_W];
    assign quot      = quot_reg[QUOT_W];
    assign ovf       = ovf_reg[QUOT_W];
    assign tag_out   = tag_reg[QUOT_W];

endmodule

// ===== rtl/ddm_back.sv =====
// ----------------------------------------------------------------------------
// ddm_back: scaling, division, mixing and motor drive
// Multiplies each stick offset by the output span, divides by the input span
// in two parallel divider pipelines, then mixes and drives both sides. The
// whole pipeline advances whenever the result queue has room.
// ----------------------------------------------------------------------------
module ddm_back #(
    parameter int PWM_BITS = ddm_pkg::PWM_BITS_DEFAULT
) (
    input  logic             clk,
    input  logic             rst_n,
    input  ddm_pkg::cmd_t    cmd,
    input  logic             cmd_empty,
    output logic             cmd_pop,
    input  logic             res_full,
    output logic             res_push,
    output ddm_pkg::result_t res
);
    import ddm_pkg::*;

    localparam int PWM_MAX = (1 << PWM_BITS) - 1;
    localparam int SCALE_W = PWM_BITS + 1;
    localparam int NUM_W   = STICK_W + SCALE_W;
    localparam int SAT_W   = QUOT_W + 2;
    localparam int MAG_W   = STICK_W + 1;

    logic                      en;

    logic                      m_valid_reg;
    cmd_t                      m_cmd_reg;
    logic [NUM_W-1:0]          m_num_a_reg;
    logic [NUM_W-1:0]          m_num_b_reg;

    head_tag_t                 tag_a_in;
    lane_tag_t                 tag_b_in;
    logic                      da_valid;
    logic [QUOT_W-1:0]         da_quot;
    logic                      da_ovf;
    head_tag_t                 da_tag;
    logic                      db_valid;
    logic [QUOT_W-1:0]         db_quot;
    logic                      db_ovf;
    lane_tag_t                 db_tag;

    logic                      p_valid_reg;
    ctrl_t                     p_ctrl_reg;
    logic signed [STICK_W-1:0] p_x_reg;
    logic signed [STICK_W-1:0] p_y_reg;

    logic signed [SAT_W-1:0]   xe;
    logic signed [SAT_W-1:0]   ye;
    logic signed [STICK_W-1:0] sum;
    logic signed [STICK_W-1:0] dif;

    logic                      q_valid_reg;
    logic                      q_flip_reg;
    logic signed [STICK_W-1:0] q_left_cmd_reg;
    logic signed [STICK_W-1:0] q_left_cmd_next;
    logic signed [STICK_W-1:0] q_right_cmd_reg;
    logic signed [STICK_W-1:0] q_right_cmd_next;
    logic                      q_left_en_reg;
    logic                      q_left_en_next;
    logic                      q_right_en_reg;
    logic                      q_right_en_next;
    logic                      q_left_wr_reg;
    logic                      q_left_wr_next;
    logic                      q_right_wr_reg;
    logic                      q_right_wr_next;

    function automatic logic signed [STICK_W-1:0] sat16(input logic signed [SAT_W-1:0] v);
        logic signed [STICK_W-1:0] r;
        if (v > 32767)
        begin
            r = 16'sh7FFF;
        end
        else if (v < -32768)
        begin
            r = 16'sh8000;
        end
        else
        begin
            r = v[STICK_W-1:0];
        end
        return r;
    endfunction

    // Signed quotient minus the PWM maximum, saturated; zero for a zero span. A
    // quotient that did not fit the divider saturates in the direction of its sign.
    function automatic logic signed [STICK_W-1:0] map_value(input logic [QUOT_W-1:0] q,
                                                           input logic ovf,
                                                           input lane_tag_t t);
        logic signed [SAT_W-1:0]   v;
        logic signed [STICK_W-1:0] r;
        v = t.neg ? -$signed({2'b00, q}) : $signed({2'b00, q});
        v = v - SAT_W'(PWM_MAX);
        if (t.zero)
        begin
            r = '0;
        end
        else if (ovf)
        begin
            r = t.neg ? 16'sh8000 : 16'sh7FFF;
        end
        else
        begin
            r = sat16(v);
        end
        return r;
    endfunction

    function automatic side_t drive(input logic signed [STICK_W-1:0] c,
                                    input logic enabled,
                                    input logic written,
                                    input logic flip);
        logic signed [MAG_W-1:0] cx;
        logic [MAG_W-1:0]        mag;
        side_t                   s;
        cx  = MAG_W'(c);
        mag = cx[MAG_W-1] ? MAG_W'(-cx) : MAG_W'(cx);
        if (mag <= MAG_W'(1))
        begin
            mag = '0;
        end
        if (mag > MAG_W'(PWM_MAX))
        begin
            mag = MAG_W'(PWM_MAX);
        end
        s = '0;
        if (written)
        begin
            s.written = 1'b1;
            if (enabled && (mag != '0))
            begin
                s.speed     = mag[SPEED_W-1:0];
                s.direction = c[STICK_W-1] ? DIR_REVERSE : DIR_FORWARD;
                s.flipped   = flip;
            end
        end
        return s;
    endfunction

    assign en       = !res_full;
    assign cmd_pop  = en && !cmd_empty;
    assign res_push = en && q_valid_reg;

    // Scale stage: offset magnitude times twice the PWM maximum.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            m_valid_reg <= !cmd_empty;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m_cmd_reg   <= cmd;
            m_num_a_reg <= NUM_W'(cmd.a.diff_mag) * NUM_W'(2 * PWM_MAX);
            m_num_b_reg <= NUM_W'(cmd.b.diff_mag) * NUM_W'(2 * PWM_MAX);
        end
    end

    always_comb
    begin
        tag_a_in.ctrl      = m_cmd_reg.ctrl;
        tag_a_in.lane.neg  = m_cmd_reg.a.neg;
        tag_a_in.lane.zero = m_cmd_reg.a.zero;
        tag_b_in.neg       = m_cmd_reg.b.neg;
        tag_b_in.zero      = m_cmd_reg.b.zero;
    end

    ddm_divider #(
        .NUM_W  (NUM_W),
        .QUOT_W (QUOT_W),
        .TAG_W  ($bits(head_tag_t))
    ) u_div_a (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (m_valid_reg),
        .num       (m_num_a_reg),
        .den       (m_cmd_reg.a.span_mag),
        .tag_in    (tag_a_in),
        .out_valid (da_valid),
        .quot      (da_quot),
        .ovf       (da_ovf),
        .tag_out   (da_tag)
    );

    ddm_divider #(
        .NUM_W  (NUM_W),
        .QUOT_W (QUOT_W),
        .TAG_W  ($bits(lane_tag_t))
    ) u_div_b (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (m_valid_reg),
        .num       (m_num_b_reg),
        .den       (m_cmd_reg.b.span_mag),
        .tag_in    (tag_b_in),
        .out_valid (db_valid),
        .quot      (db_quot),
        .ovf       (db_ovf),
        .tag_out   (db_tag)
    );

    // Map stage.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            p_valid_reg <= da_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_ctrl_reg <= da_tag.ctrl;
            p_x_reg    <= map_value(da_quot, da_ovf, da_tag.lane);
            p_y_reg    <= map_value(db_quot, db_ovf, db_tag);
        end
    end

    // Mix stage: lane a carries x or the left stick, lane b y or the right.
    assign xe  = SAT_W'(p_x_reg);
    assign ye  = SAT_W'(p_y_reg);
    assign sum = sat16(ye + xe);
    assign dif = sat16(ye - xe);

    always_comb
    begin
        q_left_cmd_next  = '0;
        q_right_cmd_next = '0;
        q_left_en_next   = p_ctrl_reg.left_en;
        q_right_en_next  = p_ctrl_reg.right_en;
        q_left_wr_next   = 1'b0;
        q_right_wr_next  = 1'b0;
        unique case (p_ctrl_reg.mode)
            MODE_ARCADE:
            begin
                q_left_cmd_next  = p_ctrl_reg.flip ? dif : sum;
                q_right_cmd_next = p_ctrl_reg.flip ? sum : dif;
                q_left_wr_next   = 1'b1;
                q_right_wr_next  = 1'b1;
            end
            MODE_TANK:
            begin
                q_left_cmd_next  = p_ctrl_reg.flip ? p_y_reg : p_x_reg;
                q_right_cmd_next = p_ctrl_reg.flip ? p_x_reg : p_y_reg;
                q_left_wr_next   = 1'b1;
                q_right_wr_next  = 1'b1;
            end
            MODE_SINGLE:
            begin
                // The single enable governs whichever side is picked.
                q_left_cmd_next  = p_x_reg;
                q_right_cmd_next = p_x_reg;
                q_right_en_next  = p_ctrl_reg.left_en;
                q_left_wr_next   = p_ctrl_reg.pick_left;
                q_right_wr_next  = !p_ctrl_reg.pick_left;
            end
            default:
            begin
                q_left_wr_next  = 1'b0;
                q_right_wr_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            q_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            q_valid_reg <= p_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            q_flip_reg      <= p_ctrl_reg.flip;
            q_left_cmd_reg  <= q_left_cmd_next;
            q_right_cmd_reg <= q_right_cmd_next;
            q_left_en_reg   <= q_left_en_next;
            q_right_en_reg  <= q_right_en_next;
            q_left_wr_reg   <= q_left_wr_next;
            q_right_wr_reg  <= q_right_wr_next;
        end
    end

    always_comb
    begin
        res.left  = drive(q_left_cmd_reg, q_left_en_reg, q_left_wr_reg, q_flip_reg);
        res.right = drive(q_right_cmd_reg, q_right_en_reg, q_right_wr_reg, q_flip_reg);
    end

    a_lanes_aligned: assert property (@(posedge clk) disable iff (!rst_n)
        da_valid == db_valid)
        else $error("divider lanes out of step");

    a_hold_when_blocked: assert property (@(posedge clk) disable iff (!rst_n)
        res_full |=> $stable(q_valid_reg) && (!q_valid_reg || $stable(q_left_cmd_reg)))
        else $error("drive stage moved while the result queue was full");

endmodule

// ===== rtl/differential_drive_mixer_top.sv =====
// ----------------------------------------------------------------------------
// differential_drive_mixer_top: arcade / tank / single-motor drive mixer
// Maps stick values to signed PWM commands and turns them into a speed and a
// direction for the left and the right motor.
//
//   Channel   Handshake            Beat contents
//   config    cfg_valid/cfg_ready  cfg_index, cfg_data (range registers)
//   command   push/full            mode, sticks, orientation, enables, pick
//   result    pop/empty            speed, direction, flipped, written per side
//
// Per cycle one command enters unless full and one result leaves unless empty.
// A command passes through the command queue, the scale stage, the divider
// pipelines (an entry stage followed by 17 one-bit quotient stages), the map
// stage and the mix stage, then waits in the result queue until popped.
// Reset restores the range registers to -512..511 and empties both queues.
// A full result queue freezes the back pipeline; commands still collect in
// the four-entry command queue until it fills.
// ----------------------------------------------------------------------------
module differential_drive_mixer_top #(
    parameter int PWM_BITS = ddm_pkg::PWM_BITS_DEFAULT
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [1:0]                         cfg_index,
    input  logic signed [ddm_pkg::STICK_W-1:0] cfg_data,
    input  logic                               push,
    output logic                               full,
    input  logic [1:0]                         mode,
    input  logic signed [ddm_pkg::STICK_W-1:0] stick_a,
    input  logic signed [ddm_pkg::STICK_W-1:0] stick_b,
    input  logic                               inverted,
    input  logic                               left_enable,
    input  logic                               right_enable,
    input  logic                               pick_left,
    output logic                               empty,
    input  logic                               pop,
    output logic [ddm_pkg::SPEED_W-1:0]        left_pwm,
    output logic [1:0]                         left_direction,
    output logic                               left_flipped,
    output logic                               left_written,
    output logic [ddm_pkg::SPEED_W-1:0]        right_pwm,
    output logic [1:0]                         right_direction,
    output logic                               right_flipped,
    output logic                               right_written
);
    import ddm_pkg::*;

    cmd_t    front_cmd;
    logic    cmd_push;
    logic    cmd_full;
    cmd_t    queue_cmd;
    logic    cmd_empty;
    logic    cmd_pop;
    logic    res_push;
    logic    res_full;
    result_t back_res;
    result_t out_res;

    ddm_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .push         (push),
        .full         (full),
        .mode         (mode),
        .stick_a      (stick_a),
        .stick_b      (stick_b),
        .inverted     (inverted),
        .left_enable  (left_enable),
        .right_enable (right_enable),
        .pick_left    (pick_left),
        .queue_full   (cmd_full),
        .cmd_push     (cmd_push),
        .cmd          (front_cmd)
    );

    ddm_fifo #(
        .W     ($bits(cmd_t)),
        .DEPTH (CMD_DEPTH)
    ) u_cmd_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (cmd_push),
        .wr_data (front_cmd),
        .full    (cmd_full),
        .pop     (cmd_pop),
        .rd_data (queue_cmd),
        .empty   (cmd_empty)
    );

    ddm_back #(
        .PWM_BITS (PWM_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (queue_cmd),
        .cmd_empty (cmd_empty),
        .cmd_pop   (cmd_pop),
        .res_full  (res_full),
        .res_push  (res_push),
        .res       (back_res)
    );

    ddm_fifo #(
        .W     ($bits(result_t)),
        .DEPTH (RES_DEPTH)
    ) u_res_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (res_push),
        .wr_data (back_res),
        .full    (res_full),
        .pop     (pop),
        .rd_data (out_res),
        .empty   (empty)
    );

    assign left_pwm        = out_res.left.speed;
    assign left_direction  = out_res.left.direction;
    assign left_flipped    = out_res.left.flipped;
    assign left_written    = out_res.left.written;
    assign right_pwm       = out_res.right.speed;
    assign right_direction = out_res.right.direction;
    assign right_flipped   = out_res.right.flipped;
    assign right_written   = out_res.right.written;

endmodule

// ===== tb/tb_differential_drive_mixer_top.sv =====
// ----------------------------------------------------------------------------
// tb_differential_drive_mixer_top: self-checking bench for the drive mixer
// Sends directed and random drive commands under several stick range settings
// and with different amounts of idling on both queues. A scoreboard predicts
// every result beat and compares it field by field with what the block pops.
// ----------------------------------------------------------------------------
module tb_differential_drive_mixer_top;
    import ddm_pkg::*;

    localparam int         CYCLE_LIMIT = 200000;
    localparam int         PHASES      = 8;
    localparam int         PHASE_ITEMS = 125;
    localparam longint     PWM_MAX     = (longint'(1) << PWM_BITS_DEFAULT) - 1;
    localparam logic [1:0] MODE_UNKNOWN = 2'd3;

    typedef struct {
        logic [1:0]                mode;
        logic signed [STICK_W-1:0] stick_a;
        logic signed [STICK_W-1:0] stick_b;
        logic                      flip;
        logic                      left_en;
        logic                      right_en;
        logic                      pick_left;
    } drive_cmd_t;

    class drive_scoreboard;
        result_t expected_q[$];
        int      lat_lo;
        int      lat_hi;
        int      fwd_lo;
        int      fwd_hi;
        int      errors;
        int      checked;

        function new();
            lat_lo  = LATERAL_MIN_RESET;
            lat_hi  = LATERAL_MAX_RESET;
            fwd_lo  = FORWARD_MIN_RESET;
            fwd_hi  = FORWARD_MAX_RESET;
            errors  = 0;
            checked = 0;
        endfunction

        function void set_range(reg_index_t idx, logic signed [STICK_W-1:0] v);
            case (idx)
                REG_LATERAL_MIN: lat_lo = v;
                REG_LATERAL_MAX: lat_hi = v;
                REG_FORWARD_MIN: fwd_lo = v;
                REG_FORWARD_MAX: fwd_hi = v;
                default: ;
            endcase
        endfunction

        function int clamp16(longint v);
            if (v > 32767)
                return 32767;
            if (v < -32768)
                return -32768;
            return int'(v);
        endfunction

        // Linear map of a stick onto -PWM_MAX..PWM_MAX, truncating toward zero.
        function int scale_stick(int v, int lo, int hi);
            longint span;
            longint num;
            span = longint'(hi) - longint'(lo);
            if (span == 0)
                return 0;
            num = (longint'(v) - longint'(lo)) * (2 * PWM_MAX);
            return clamp16(num / span - PWM_MAX);
        endfunction

        function side_t motor_side(int cmd, logic en, logic flip);
            side_t s;
            int    mag;
            if (cmd >= -1 && cmd <= 1)
                cmd = 0;
            mag = (cmd < 0) ? -cmd : cmd;
            if (mag > PWM_MAX)
                mag = int'(PWM_MAX);
            s.written = 1'b1;
            if (!en || mag == 0)
            begin
                s.speed     = '0;
                s.direction = DIR_STOP;
                s.flipped   = 1'b0;
            end
            else
            begin
                s.speed     = mag[SPEED_W-1:0];
                s.direction = (cmd < 0) ? DIR_REVERSE : DIR_FORWARD;
                s.flipped   = flip;
            end
            return s;
        endfunction

        function void note_cmd(drive_cmd_t c);
            result_t r;
            int      x;
            int      y;
            int      sum;
            int      dif;
            r = '0;
            case (c.mode)
                MODE_ARCADE:
                begin
                    x       = scale_stick(c.stick_a, lat_lo, lat_hi);
                    y       = scale_stick(c.stick_b, fwd_lo, fwd_hi);
                    sum     = clamp16(longint'(y) + x);
                    dif     = clamp16(longint'(y) - x);
                    r.left  = motor_side(c.flip ? dif : sum, c.left_en, c.flip);
                    r.right = motor_side(c.flip ? sum : dif, c.right_en, c.flip);
                end
                MODE_TANK:
                begin
                    x       = scale_stick(c.stick_a, fwd_lo, fwd_hi);
                    y       = scale_stick(c.stick_b, fwd_lo, fwd_hi);
                    r.left  = motor_side(c.flip ? y : x, c.left_en, c.flip);
                    r.right = motor_side(c.flip ? x : y, c.right_en, c.flip);
                end
                MODE_SINGLE:
                begin
                    x = scale_stick(c.stick_a, fwd_lo, fwd_hi);
                    // The one enable is the left one, whichever side is picked.
                    if (c.pick_left)
                        r.left = motor_side(x, c.left_en, c.flip);
                    else
                        r.right = motor_side(x, c.left_en, c.flip);
                end
                default: ;
            endcase
            expected_q.push_back(r);
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function void check_field(string name, int want, int got);
            if (want != got)
            begin
                $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
                errors++;
            end
        endfunction

        function void check_result(result_t got);
            result_t want;
            if (expected_q.size() == 0)
            begin
                $display("%0t: result beat with no command outstanding, expected none, actual %h",
                         $time, got);
                errors++;
                return;
            end
            want = expected_q.pop_front();
            checked++;
            check_field("left_pwm", want.left.speed, got.left.speed);
            check_field("left_direction", want.left.direction, got.left.direction);
            check_field("left_flipped", want.left.flipped, got.left.flipped);
            check_field("left_written", want.left.written, got.left.written);
            check_field("right_pwm", want.right.speed, got.right.speed);
            check_field("right_direction", want.right.direction, got.right.direction);
            check_field("right_flipped", want.right.flipped, got.right.flipped);
            check_field("right_written", want.right.written, got.right.written);
        endfunction
    endclass

    logic                      clk = 1'b0;
    logic                      rst_n;
    logic                      cfg_valid;
    logic                      cfg_ready;
    logic [1:0]                cfg_index;
    logic signed [STICK_W-1:0] cfg_data;
    logic                      push;
    logic                      full;
    logic [1:0]                mode;
    logic signed [STICK_W-1:0] stick_a;
    logic signed [STICK_W-1:0] stick_b;
    logic                      inverted;
    logic                      left_enable;
    logic                      right_enable;
    logic                      pick_left;
    logic                      empty;
    logic                      pop;
    logic [SPEED_W-1:0]        left_pwm;
    logic [1:0]                left_direction;
    logic                      left_flipped;
    logic                      left_written;
    logic [SPEED_W-1:0]        right_pwm;
    logic [1:0]                right_direction;
    logic                      right_flipped;
    logic                      right_written;

    drive_scoreboard sb = new();
    int              gap_pct = 0;
    int              stall_pct = 0;
    int              cycle_count = 0;
    int              mode_count [4] = '{0, 0, 0, 0};
    reg_index_t      reg_order [4] = '{REG_LATERAL_MIN, REG_LATERAL_MAX,
                                       REG_FORWARD_MIN, REG_FORWARD_MAX};

    differential_drive_mixer_top dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .push            (push),
        .full            (full),
        .mode            (mode),
        .stick_a         (stick_a),
        .stick_b         (stick_b),
        .inverted        (inverted),
        .left_enable     (left_enable),
        .right_enable    (right_enable),
        .pick_left       (pick_left),
        .empty           (empty),
        .pop             (pop),
        .left_pwm        (left_pwm),
        .left_direction  (left_direction),
        .left_flipped    (left_flipped),
        .left_written    (left_written),
        .right_pwm       (right_pwm),
        .right_direction (right_direction),
        .right_flipped   (right_flipped),
        .right_written   (right_written)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles with %0d results outstanding",
                     cycle_count, sb.pending());
            $display("FAILURE");
            $finish;
        end
    end

    // Result side: sample at the edge, then decide whether to pop next cycle.
    initial
    begin
        result_t got;
        pop <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && pop && !empty)
            begin
                got.left.speed      = left_pwm;
                got.left.direction  = dir_t'(left_direction);
                got.left.flipped    = left_flipped;
                got.left.written    = left_written;
                got.right.speed     = right_pwm;
                got.right.direction = dir_t'(right_direction);
                got.right.flipped   = right_flipped;
                got.right.written   = right_written;
                sb.check_result(got);
            end
            pop <= (stall_pct == 0) || ($urandom_range(0, 99) >= stall_pct);
        end
    end

    function automatic drive_cmd_t make_cmd(logic [1:0] m, int a, int b, logic f,
                                            logic le, logic re, logic pl);
        drive_cmd_t c;
        c.mode      = m;
        c.stick_a   = a[STICK_W-1:0];
        c.stick_b   = b[STICK_W-1:0];
        c.flip      = f;
        c.left_en   = le;
        c.right_en  = re;
        c.pick_left = pl;
        return c;
    endfunction

    // Half the values inside the configured range, plus edges, values near zero and wild values.
    function automatic logic signed [STICK_W-1:0] pick_stick(int r0, int r1);
        int lo;
        int hi;
        int v;
        lo = (r0 < r1) ? r0 : r1;
        hi = (r0 < r1) ? r1 : r0;
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: v = lo + int'($urandom_range(0, hi - lo));
            5, 6:          v = int'($urandom);
            7:             v = $urandom_range(0, 1) ? -32768 : 32767;
            8:             v = int'($urandom_range(0, 16)) - 8;
            default:       v = ($urandom_range(0, 1) ? lo : hi) + int'($urandom_range(0, 2)) - 1;
        endcase
        return v[STICK_W-1:0];
    endfunction

    function automatic drive_cmd_t random_cmd();
        drive_cmd_t c;
        int         sel;
        sel = $urandom_range(0, 15);
        if (sel < 6)
            c.mode = MODE_ARCADE;
        else if (sel < 11)
            c.mode = MODE_TANK;
        else if (sel < 15)
            c.mode = MODE_SINGLE;
        else
            c.mode = MODE_UNKNOWN;
        if (c.mode == MODE_ARCADE)
            c.stick_a = pick_stick(sb.lat_lo, sb.lat_hi);
        else
            c.stick_a = pick_stick(sb.fwd_lo, sb.fwd_hi);
        c.stick_b   = pick_stick(sb.fwd_lo, sb.fwd_hi);
        c.flip      = 1'($urandom_range(0, 1));
        c.left_en   = $urandom_range(0, 99) < 85;
        c.right_en  = $urandom_range(0, 99) < 85;
        c.pick_left = 1'($urandom_range(0, 1));
        return c;
    endfunction

    task automatic send_cmd(input drive_cmd_t c);
        while (gap_pct != 0 && $urandom_range(0, 99) < gap_pct)
        begin
            push <= 1'b0;
            @(posedge clk);
        end
        push         <= 1'b1;
        mode         <= c.mode;
        stick_a      <= c.stick_a;
        stick_b      <= c.stick_b;
        inverted     <= c.flip;
        left_enable  <= c.left_en;
        right_enable <= c.right_en;
        pick_left    <= c.pick_left;
        @(posedge clk);
        while (full)
            @(posedge clk);
        sb.note_cmd(c);
        mode_count[c.mode]++;
    endtask

    task automatic pause_until_drained();
        push <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    // All four range registers in one burst; valid stays high between beats.
    task automatic write_ranges(input int lat_min, input int lat_max,
                                input int fwd_min, input int fwd_max);
        int vals [4];
        vals = '{lat_min, lat_max, fwd_min, fwd_max};
        for (int k = 0; k < 4; k++)
        begin
            cfg_valid <= 1'b1;
            cfg_index <= reg_order[k];
            cfg_data  <= vals[k][STICK_W-1:0];
            @(posedge clk);
            while (!cfg_ready)
                @(posedge clk);
            sb.set_range(reg_order[k], vals[k][STICK_W-1:0]);
        end
        cfg_valid <= 1'b0;
    endtask

    initial
    begin
        rst_n        <= 1'b0;
        cfg_valid    <= 1'b0;
        cfg_index    <= REG_LATERAL_MIN;
        cfg_data     <= '0;
        push         <= 1'b0;
        mode         <= MODE_ARCADE;
        stick_a      <= '0;
        stick_b      <= '0;
        inverted     <= 1'b0;
        left_enable  <= 1'b0;
        right_enable <= 1'b0;
        pick_left    <= 1'b0;
        repeat (5)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed commands under the reset ranges of -512..511.
        send_cmd(make_cmd(MODE_ARCADE, 0, 0, 1, 1, 1, 0));
        send_cmd(make_cmd(MODE_ARCADE, -512, 511, 0, 1, 1, 0));
        send_cmd(make_cmd(MODE_ARCADE, 511, 511, 1, 1, 1, 1));
        send_cmd(make_cmd(MODE_ARCADE, 511, -512, 0, 1, 1, 0));
        send_cmd(make_cmd(MODE_ARCADE, 32767, -32768, 1, 1, 1, 0));
        send_cmd(make_cmd(MODE_ARCADE, -32768, -32768, 0, 1, 1, 1));
        send_cmd(make_cmd(MODE_ARCADE, 300, -200, 0, 0, 0, 0));
        send_cmd(make_cmd(MODE_TANK, -512, 511, 0, 1, 0, 0));
        send_cmd(make_cmd(MODE_TANK, 100, -300, 1, 1, 1, 0));
        send_cmd(make_cmd(MODE_TANK, 511, 511, 0, 1, 0, 1));
        // Sticks of 2 and -1 map to +1 and -1, which must come out as a stop.
        send_cmd(make_cmd(MODE_TANK, 2, -1, 0, 1, 1, 0));
        send_cmd(make_cmd(MODE_TANK, 4, 32767, 1, 1, 1, 1));
        send_cmd(make_cmd(MODE_TANK, -32768, 0, 1, 1, 1, 0));
        send_cmd(make_cmd(MODE_SINGLE, 511, 0, 0, 1, 0, 1));
        send_cmd(make_cmd(MODE_SINGLE, -512, 0, 1, 1, 1, 0));
        send_cmd(make_cmd(MODE_SINGLE, 400, 0, 0, 0, 1, 0));
        send_cmd(make_cmd(MODE_SINGLE, 2, 32767, 1, 1, 1, 1));
        send_cmd(make_cmd(MODE_SINGLE, 32767, -32768, 1, 1, 0, 1));
        send_cmd(make_cmd(MODE_UNKNOWN, 511, -512, 1, 1, 1, 1));
        send_cmd(make_cmd(MODE_UNKNOWN, -32768, 32767, 0, 0, 0, 0));

        for (int ph = 0; ph < PHASES; ph++)
        begin
            pause_until_drained();
            case (ph)
                0: write_ranges(-32768, 32767, -32768, 32767);
                1: write_ranges(7, 7, -1000, 1000);
                2: write_ranges(511, -512, 32767, -32768);
                3: write_ranges(0, 1, -1, 1);
                4: write_ranges(int'($urandom), int'($urandom), int'($urandom), int'($urandom));
                5: write_ranges(-300, 300, 250, 250);
                6: write_ranges(-512, 511, -512, 511);
                default: write_ranges(-32768, -32768, 32767, -32768);
            endcase
            case (ph % 4)
                0:
                begin
                    gap_pct   = 0;
                    stall_pct = 0;
                end
                1:
                begin
                    gap_pct   = 46;
                    stall_pct = 0;
                end
                2:
                begin
                    gap_pct   = 0;
                    stall_pct = 46;
                end
                default:
                begin
                    gap_pct   = 36;
                    stall_pct = 36;
                end
            endcase
            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                if (i == PHASE_ITEMS / 2 && ph % 3 == 1)
                    pause_until_drained();
                send_cmd(random_cmd());
            end
        end

        pause_until_drained();
        repeat (40)
            @(posedge clk);

        $display("Checked %0d results across %0d range settings and four idling patterns.",
                 sb.checked, PHASES + 1);
        $display("Commands: %0d arcade, %0d tank, %0d single motor, %0d unknown mode.",
                 mode_count[MODE_ARCADE], mode_count[MODE_TANK],
                 mode_count[MODE_SINGLE], mode_count[MODE_UNKNOWN]);
        if (sb.errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
